// ===== design/capov_pkg.sv =====
// ----------------------------------------------------------------------------
// capov_pkg
// Types, widths and register indexes shared by the capsule overlap test.
// ----------------------------------------------------------------------------
package capov_pkg;

  localparam int CoordW  = 16;  // signed Q8.8 coordinate
  localparam int RadiusW = 15;  // unsigned Q7.8 radius
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;  // widest register

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [RadiusW-1:0]       radius_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;
  typedef logic [CfgW-1:0]          cfg_data_t;

  // intermediate formats
  typedef logic signed [16:0] diff_t;    // Q9.8 difference
  typedef logic signed [33:0] prod_t;    // product of two differences
  typedef logic signed [35:0] dot_t;     // sum of three products
  typedef logic [34:0]        len2_t;    // sum of three squares
  typedef logic [33:0]        cmag_t;    // magnitude of a cross component
  typedef logic [15:0]        rsum_t;
  typedef logic [31:0]        r2_t;
  typedef logic [67:0]        csq_t;     // square of a cross component
  typedef logic [66:0]        bound_t;   // r^2 * |d|^2
  typedef logic [69:0]        cross2_t;  // |d x w|^2

  localparam cfg_idx_t RegEndAX    = 3'd0;
  localparam cfg_idx_t RegEndAY    = 3'd1;
  localparam cfg_idx_t RegEndAZ    = 3'd2;
  localparam cfg_idx_t RegEndBX    = 3'd3;
  localparam cfg_idx_t RegEndBY    = 3'd4;
  localparam cfg_idx_t RegEndBZ    = 3'd5;
  localparam cfg_idx_t RegCapRadius = 3'd6;

endpackage

// ===== design/capsule_overlap_test.sv =====
// ----------------------------------------------------------------------------
// capsule_overlap_test
// Sphere against capsule overlap test in exact fixed point, five stage pipe.
// ----------------------------------------------------------------------------
// each request passes through the stage 1 to stage 5 registers to its result
// throughput: one request per cycle unless stalled, from fully pipelined multipliers
// each stage holds its data while the stage after it is full and stalled
// reset: synchronous active low, clears stage valid bits and the capsule registers
// ----------------------------------------------------------------------------
module capsule_overlap_test #(
  parameter int DIMENSIONS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  capov_pkg::cfg_idx_t  cfg_index,
  input  capov_pkg::cfg_data_t cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  capov_pkg::coord_t    in_point_x,
  input  capov_pkg::coord_t    in_point_y,
  input  capov_pkg::coord_t    in_point_z,
  input  capov_pkg::radius_t   in_query_radius,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_overlap
);
  import capov_pkg::*;

  localparam logic UseZ = (DIMENSIONS == 3);

  // configuration registers
  coord_t  a_x_r, a_y_r, a_z_r, b_x_r, b_y_r, b_z_r;
  radius_t cap_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_x_r   <= '0;
      a_y_r   <= '0;
      a_z_r   <= '0;
      b_x_r   <= '0;
      b_y_r   <= '0;
      b_z_r   <= '0;
      cap_r_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegEndAX:     a_x_r   <= coord_t'(cfg_data);
        RegEndAY:     a_y_r   <= coord_t'(cfg_data);
        RegEndAZ:     a_z_r   <= coord_t'(cfg_data);
        RegEndBX:     b_x_r   <= coord_t'(cfg_data);
        RegEndBY:     b_y_r   <= coord_t'(cfg_data);
        RegEndBZ:     b_z_r   <= coord_t'(cfg_data);
        RegCapRadius: cap_r_r <= cfg_data[RadiusW-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage valid bits and per stage load enables
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld5;

  assign ld5      = !out_valid_r || out_ready;
  assign ld4      = !s4_valid_r || ld5;
  assign ld3      = !s3_valid_r || ld4;
  assign ld2      = !s2_valid_r || ld3;
  assign ld1      = !s1_valid_r || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) s1_valid_r  <= in_valid;
      if (ld2) s2_valid_r  <= s1_valid_r;
      if (ld3) s3_valid_r  <= s2_valid_r;
      if (ld4) s4_valid_r  <= s3_valid_r;
      if (ld5) out_valid_r <= s4_valid_r;
    end
  end

  // ---------------- stage 1: differences and radius sum ----------------
  diff_t dx_nxt, dy_nxt, dz_nxt, wx_nxt, wy_nxt, wz_nxt, ux_nxt, uy_nxt, uz_nxt;
  rsum_t rsum_nxt;
  diff_t dx_r, dy_r, dz_r, wx_r, wy_r, wz_r, ux_r, uy_r, uz_r;
  rsum_t rsum_r;

  always_comb begin
    dx_nxt = {b_x_r[15], b_x_r} - {a_x_r[15], a_x_r};
    dy_nxt = {b_y_r[15], b_y_r} - {a_y_r[15], a_y_r};
    wx_nxt = {in_point_x[15], in_point_x} - {a_x_r[15], a_x_r};
    wy_nxt = {in_point_y[15], in_point_y} - {a_y_r[15], a_y_r};
    ux_nxt = {in_point_x[15], in_point_x} - {b_x_r[15], b_x_r};
    uy_nxt = {in_point_y[15], in_point_y} - {b_y_r[15], b_y_r};
    // planar mode drops every z term
    dz_nxt = UseZ ? diff_t'({b_z_r[15], b_z_r} - {a_z_r[15], a_z_r}) : '0;
    wz_nxt = UseZ ? diff_t'({in_point_z[15], in_point_z} - {a_z_r[15], a_z_r}) : '0;
    uz_nxt = UseZ ? diff_t'({in_point_z[15], in_point_z} - {b_z_r[15], b_z_r}) : '0;
    rsum_nxt = {1'b0, cap_r_r} + {1'b0, in_query_radius};
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      dz_r   <= dz_nxt;
      wx_r   <= wx_nxt;
      wy_r   <= wy_nxt;
      wz_r   <= wz_nxt;
      ux_r   <= ux_nxt;
      uy_r   <= uy_nxt;
      uz_r   <= uz_nxt;
      rsum_r <= rsum_nxt;
    end
  end

  // ---------------- stage 2: all first level products ----------------
  prod_t dw_x_r, dw_y_r, dw_z_r;          // d.w terms
  prod_t dd_x_r, dd_y_r, dd_z_r;          // |d|^2 terms
  prod_t ww_x_r, ww_y_r, ww_z_r;          // |w|^2 terms
  prod_t uu_x_r, uu_y_r, uu_z_r;          // |p-b|^2 terms
  prod_t c_yz_r, c_zy_r, c_zx_r, c_xz_r, c_xy_r, c_yx_r;  // cross terms
  r2_t   r2_s2_r;

  function automatic prod_t smul(diff_t p, diff_t q);
    return prod_t'(p) * prod_t'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (ld2) begin
      dw_x_r  <= smul(dx_r, wx_r);
      dw_y_r  <= smul(dy_r, wy_r);
      dw_z_r  <= smul(dz_r, wz_r);
      dd_x_r  <= smul(dx_r, dx_r);
      dd_y_r  <= smul(dy_r, dy_r);
      dd_z_r  <= smul(dz_r, dz_r);
      ww_x_r  <= smul(wx_r, wx_r);
      ww_y_r  <= smul(wy_r, wy_r);
      ww_z_r  <= smul(wz_r, wz_r);
      uu_x_r  <= smul(ux_r, ux_r);
      uu_y_r  <= smul(uy_r, uy_r);
      uu_z_r  <= smul(uz_r, uz_r);
      c_yz_r  <= smul(dy_r, wz_r);
      c_zy_r  <= smul(dz_r, wy_r);
      c_zx_r  <= smul(dz_r, wx_r);
      c_xz_r  <= smul(dx_r, wz_r);
      c_xy_r  <= smul(dx_r, wy_r);
      c_yx_r  <= smul(dy_r, wx_r);
      r2_s2_r <= r2_t'(rsum_r) * r2_t'(rsum_r);
    end
  end

  // ---------------- stage 3: sums and cross magnitudes ----------------
  dot_t  dot_nxt, dot_r;
  len2_t dlen2_nxt, w2_nxt, u2_nxt, dlen2_r, w2_r, u2_r;
  cmag_t cx_nxt, cy_nxt, cz_nxt, cx_r, cy_r, cz_r;
  r2_t   r2_s3_r;

  function automatic cmag_t cross_mag(prod_t p, prod_t q);
    logic signed [34:0] c;
    logic signed [34:0] m;
    c = 35'(p) - 35'(q);
    m = c[34] ? -c : c;
    return m[33:0];
  endfunction

  function automatic len2_t sq_sum(prod_t p, prod_t q, prod_t s);
    // squares are never negative and stay within 33 bits
    return {2'b00, p[32:0]} + {2'b00, q[32:0]} + {2'b00, s[32:0]};
  endfunction

  always_comb begin
    dot_nxt   = 36'(dw_x_r) + 36'(dw_y_r) + 36'(dw_z_r);
    dlen2_nxt = sq_sum(dd_x_r, dd_y_r, dd_z_r);
    w2_nxt    = sq_sum(ww_x_r, ww_y_r, ww_z_r);
    u2_nxt    = sq_sum(uu_x_r, uu_y_r, uu_z_r);
    cx_nxt    = cross_mag(c_yz_r, c_zy_r);
    cy_nxt    = cross_mag(c_zx_r, c_xz_r);
    cz_nxt    = cross_mag(c_xy_r, c_yx_r);
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      dot_r   <= dot_nxt;
      dlen2_r <= dlen2_nxt;
      w2_r    <= w2_nxt;
      u2_r    <= u2_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      cz_r    <= cz_nxt;
      r2_s3_r <= r2_s2_r;
    end
  end

  // ---------------- stage 4: wide squares, region and endpoint test ----------------
  logic   before_a, past_b;
  logic   inside_nxt, end_hit_nxt;
  logic   inside_r, end_hit_r;
  csq_t   cx2_r, cy2_r, cz2_r;
  bound_t bound_r;

  always_comb begin
    before_a    = dot_r[35] || (dot_r == '0);
    past_b      = $signed(37'(dot_r)) >= $signed({2'b00, dlen2_r});
    inside_nxt  = !before_a && !past_b;
    end_hit_nxt = before_a ? (w2_r < {3'b000, r2_s3_r}) : (u2_r < {3'b000, r2_s3_r});
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      cx2_r     <= csq_t'(cx_r) * csq_t'(cx_r);
      cy2_r     <= csq_t'(cy_r) * csq_t'(cy_r);
      cz2_r     <= csq_t'(cz_r) * csq_t'(cz_r);
      bound_r   <= bound_t'(r2_s3_r) * bound_t'(dlen2_r);
      inside_r  <= inside_nxt;
      end_hit_r <= end_hit_nxt;
    end
  end

  // ---------------- stage 5: cross sum compare, output register ----------------
  cross2_t cross2;
  logic    hit_nxt, overlap_r;

  always_comb begin
    cross2  = 70'(cx2_r) + 70'(cy2_r) + 70'(cz2_r);
    hit_nxt = inside_r ? (cross2 < 70'(bound_r)) : end_hit_r;
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      overlap_r <= hit_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = overlap_r;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the capsule / sphere overlap test.
// Each request is predicted with exact wide integer math against a shadow copy
// of the capsule registers, then compared in order with what the block returns.
// Directed corner requests come first, then near-capsule random traffic under
// several sender and receiver stall mixes, a long output stall, and a drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import capov_pkg::*;

  localparam int          Dims        = 3;
  localparam int          CycleLimit  = 400000;
  localparam int          HoldCycles  = 300;
  localparam int          SettleCycles = 12;
  localparam cfg_idx_t    RegUnused   = 3'd7;

  typedef coord_t vec3_t [3];

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;
  logic      in_valid;
  logic      in_ready;
  coord_t    in_point_x;
  coord_t    in_point_y;
  coord_t    in_point_z;
  radius_t   in_query_radius;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      out_overlap;

  // shadow of the capsule registers
  vec3_t     end_a = '{default: '0};
  vec3_t     end_b = '{default: '0};
  radius_t   cap_radius = '0;

  bit          overlap_q[$];
  int          fails = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_go = 1'b0;
  logic        holding = 1'b0;
  int unsigned cycles = 0;

  capsule_overlap_test #(
    .DIMENSIONS(Dims)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_query_radius(in_query_radius),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_overlap    (out_overlap)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // exact overlap prediction from the shadow registers
  function automatic bit predict_overlap(coord_t px, coord_t py, coord_t pz, radius_t qr);
    longint ax, ay, az, bx, by, bz, cz_p;
    longint dx, dy, dz, wx, wy, wz, ux, uy, uz;
    longint dot, dlen2, dist2, rsum, r2, cx, cy, cz;
    logic [127:0] cross2, bound, t;
    ax = longint'(end_a[0]);
    ay = longint'(end_a[1]);
    az = longint'(end_a[2]);
    bx = longint'(end_b[0]);
    by = longint'(end_b[1]);
    bz = longint'(end_b[2]);
    cz_p = longint'(pz);
    if (Dims == 2) begin
      az = 0;
      bz = 0;
      cz_p = 0;
    end
    rsum = longint'(cap_radius) + longint'(qr);
    r2 = rsum * rsum;
    dx = bx - ax;
    dy = by - ay;
    dz = bz - az;
    wx = longint'(px) - ax;
    wy = longint'(py) - ay;
    wz = cz_p - az;
    dot = dx * wx + dy * wy + dz * wz;
    dlen2 = dx * dx + dy * dy + dz * dz;
    if (dot <= 0) begin
      dist2 = wx * wx + wy * wy + wz * wz;
      return dist2 < r2;
    end else if (dot >= dlen2) begin
      ux = longint'(px) - bx;
      uy = longint'(py) - by;
      uz = cz_p - bz;
      dist2 = ux * ux + uy * uy + uz * uz;
      return dist2 < r2;
    end
    // projection lands inside the segment: compare |d x w|^2 with R^2 |d|^2
    cx = dy * wz - dz * wy;
    cy = dz * wx - dx * wz;
    cz = dx * wy - dy * wx;
    if (cx < 0) cx = -cx;
    if (cy < 0) cy = -cy;
    if (cz < 0) cz = -cz;
    t = 128'(cx);
    cross2 = t * t;
    t = 128'(cy);
    cross2 = cross2 + t * t;
    t = 128'(cz);
    cross2 = cross2 + t * t;
    bound = 128'(r2) * 128'(dlen2);
    return cross2 < bound;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return coord_t'(-32768);
          1: return coord_t'(32767);
          2: return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
      default: return coord_t'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  // result checker and receiver stall control
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid && out_ready) begin
      if (overlap_q.size() == 0) begin
        $error("overlap: result with no request waiting, actual %0b", out_overlap);
        fails++;
      end else begin
        want = overlap_q.pop_front();
        if (out_overlap !== want) begin
          $error("overlap: expected %0b, actual %0b", want, out_overlap);
          fails++;
        end
      end
    end
    out_ready <= holding ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted here
  always begin
    @(posedge hold_go);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding <= 1'b0;
  end

  // writes every capsule register, then a stray write to the unused index
  task automatic set_capsule(input vec3_t a, input vec3_t b, input cfg_data_t rad_word);
    cfg_idx_t  regs[7];
    cfg_data_t words[7];
    regs  = '{RegEndAX, RegEndAY, RegEndAZ, RegEndBX, RegEndBY, RegEndBZ, RegCapRadius};
    words = '{a[0], a[1], a[2], b[0], b[1], b[2], rad_word};
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= (k < 7) ? regs[k] : RegUnused;
      cfg_data  <= (k < 7) ? words[k] : cfg_data_t'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    end_a = a;
    end_b = b;
    cap_radius = rad_word[RadiusW-1:0];
  endtask

  task automatic send_query(input coord_t px, input coord_t py, input coord_t pz,
                            input radius_t qr);
    bit hit;
    hit = predict_overlap(px, py, pz, qr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_point_x      <= px;
    in_point_y      <= py;
    in_point_z      <= pz;
    in_query_radius <= qr;
    do @(posedge clk); while (!in_ready);
    overlap_q.push_back(hit);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
  endtask

  // mostly points scattered around the current segment, some anywhere
  task automatic send_random_query();
    coord_t  p[3];
    radius_t qr;
    longint  base, span;
    int      t;
    bit      wild;
    t = $urandom_range(8);
    span = longint'(cap_radius) + 512;
    wild = ($urandom_range(4) == 0);
    for (int k = 0; k < 3; k++) begin
      if (wild) begin
        p[k] = coord_t'($urandom);
      end else begin
        base = longint'(end_a[k]) + (longint'(end_b[k]) - longint'(end_a[k])) * t / 8;
        base = base + longint'($urandom_range(int'(2 * span))) - span;
        if (base > 32767) base = 32767;
        if (base < -32768) base = -32768;
        p[k] = coord_t'(base);
      end
    end
    case ($urandom_range(3))
      0: qr = '0;
      1: qr = radius_t'($urandom_range(1023));
      2: qr = radius_t'($urandom);
      default: qr = radius_t'($urandom_range(255));
    endcase
    send_query(p[0], p[1], p[2], qr);
  endtask

  task automatic randomize_capsule();
    vec3_t     a, b;
    radius_t   r;
    bit        degenerate;
    degenerate = ($urandom_range(5) == 0);
    for (int k = 0; k < 3; k++) begin
      a[k] = rand_coord();
      b[k] = degenerate ? a[k] : rand_coord();
    end
    case ($urandom_range(4))
      0: r = '0;
      1: r = '1;
      2: r = radius_t'($urandom);
      default: r = radius_t'($urandom_range(1024));
    endcase
    // top data bit lies above the radius field and must be dropped
    set_capsule(a, b, {1'($urandom_range(1)), r});
  endtask

  // registers still at reset: capsule is a bare point at the origin
  task automatic test_reset_state();
    send_query(16'sh0000, 16'sh0000, 16'sh0000, 15'h0000);
    send_query(16'sh0000, 16'sh0000, 16'sh0000, 15'h0001);
    send_query(16'sh0001, 16'sh0000, 16'sh0000, 15'h0001);
    drain_results();
  endtask

  task automatic test_segment_regions();
    vec3_t a, b;
    a = '{16'sh0000, 16'sh0000, 16'sh0000};
    b = '{16'sh1000, 16'sh0000, 16'sh0000};
    set_capsule(a, b, 16'h0100);
    send_query(-16'sh0200, 16'sh0000, 16'sh0000, 15'h0080);  // behind A
    send_query(16'sh1200, 16'sh0050, 16'sh0000, 15'h0000);   // past B
    send_query(16'sh0800, 16'sh0100, 16'sh0000, 15'h0000);   // exactly on the surface
    send_query(16'sh0800, 16'sh00FF, 16'sh0000, 15'h0000);   // just inside
    send_query(16'sh1000, 16'sh0000, 16'sh0000, 15'h0000);   // projection lands on B
    send_query(16'sh0800, 16'sh7FFF, -16'sh8000, 15'h7FFF);
    send_query(-16'sh8000, -16'sh8000, -16'sh8000, 15'h7FFF);
    send_query(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h0000);
    drain_results();
  endtask

  task automatic test_extreme_capsule();
    vec3_t a, b;
    a = '{-16'sh8000, -16'sh8000, -16'sh8000};
    b = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    set_capsule(a, b, 16'hFFFF);
    send_query(16'sh0000, 16'sh0000, 16'sh0000, 15'h0000);
    send_query(-16'sh8000, 16'sh7FFF, 16'sh0000, 15'h7FFF);
    send_query(16'sh7FFF, -16'sh8000, 16'sh7FFF, 15'h0000);
    send_query(16'sh7FFF, -16'sh8000, -16'sh8000, 15'h2AAA);
    drain_results();
  endtask

  task automatic test_degenerate_segment();
    vec3_t a;
    a = '{16'sh0300, -16'sh0200, 16'sh0100};
    set_capsule(a, a, 16'h0080);
    send_query(16'sh0300, -16'sh0200, 16'sh0100, 15'h0000);
    send_query(16'sh0380, -16'sh0200, 16'sh0100, 15'h0000);
    send_query(16'sh0380, -16'sh0200, 16'sh0100, 15'h0001);
    send_query(16'sh0340, -16'sh01C0, 16'sh0140, 15'h0000);
    send_query(16'sh7FFF, 16'sh7FFF, -16'sh8000, 15'h0055);
    drain_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int c = 0; c < 5; c++) begin
      drain_results();
      randomize_capsule();
      repeat (n / 5) send_random_query();
    end
    drain_results();
  endtask

  // output held off while requests keep coming, so the pipe backs up
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    randomize_capsule();
    hold_go = 1'b1;
    repeat (60) send_random_query();
    drain_results();
  endtask

  // sender waits for the pipe to empty between bursts
  task automatic test_sender_pause();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    for (int k = 0; k < 3; k++) begin
      repeat (25) send_random_query();
      drain_results();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_point_x      = '0;
    in_point_y      = '0;
    in_point_z      = '0;
    in_query_radius = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_segment_regions();
    test_extreme_capsule();
    test_degenerate_segment();
    test_random_traffic(13, 84, 400);
    test_random_traffic(84, 13, 400);
    test_random_traffic(0, 0, 400);
    test_output_stall();
    test_sender_pause();

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/capov_pkg.sv
design/capsule_overlap_test.sv
tb/tb_top.sv
